>>> rtl/sorted_max_priority_queue_defines.svh
// Assertion macros for the sorted max priority queue.
`ifndef SORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH

// Clocked check, disabled while reset is asserted.
`define SMPQ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SMPQ_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/smpq_pkg.sv
// Shared types and constants of the sorted max priority queue.
package smpq_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int VALUE_W    = 32;
    localparam int CMD_W      = 2;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic signed [VALUE_W-1:0] EMPTY_MAX = '1;

    // Broadcast to every cell in the row.
    typedef struct packed {
        logic                      ins;
        logic                      del;
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

>>> rtl/smpq_channels.sv
// Valid/ready channel interfaces for the queue's request and response items.
interface smpq_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [smpq_pkg::CMD_W-1:0]            cmd;
    logic signed [smpq_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface smpq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [smpq_pkg::VALUE_W-1:0]   max_value;
    logic [smpq_pkg::COUNT_W-1:0]          count;
    logic                                  empty_res;
    logic [smpq_pkg::STATUS_W-1:0]         status;

    modport source (output valid, output max_value, output count, output empty_res,
                    output status, input ready);
    modport sink   (input valid, input max_value, input count, input empty_res,
                    input status, output ready);
endinterface

>>> rtl/smpq_cell.sv
// One slot of the sorted row: holds an entry and shifts with its neighbors.
module smpq_cell (
    input  logic                                 clk,
    input  smpq_pkg::cell_cmd_t                  cmd,
    input  logic                                 occupied,
    input  logic                                 left_keep,
    input  logic signed [smpq_pkg::VALUE_W-1:0]  left_entry,
    input  logic signed [smpq_pkg::VALUE_W-1:0]  right_entry,
    output logic                                 keep,
    output logic signed [smpq_pkg::VALUE_W-1:0]  entry,
    output logic signed [smpq_pkg::VALUE_W-1:0]  entry_next
);

    logic signed [smpq_pkg::VALUE_W-1:0] entry_reg;

    // Equal values stay ahead of the new one.
    assign keep = occupied && (entry_reg >= cmd.value);

    always_comb
    begin
        if (cmd.ins)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (left_keep)
                entry_next = cmd.value;
            else
                entry_next = left_entry;
        end
        else if (cmd.del)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> rtl/sorted_max_priority_queue.sv
// Sorted max priority queue: a row of DEPTH cells, head cell holds the maximum.
// Response: the result item is registered from the accepted request and is valid in the next cycle.
// Throughput: one item per cycle while the response side is ready; each cell compares against the broadcast
// value and moves at most one place per item, so the row itself never makes an item wait on another.
// Reset: count and response valid clear asynchronously; cell contents are unset.
`include "sorted_max_priority_queue_defines.svh"

module sorted_max_priority_queue #(
    parameter int DEPTH = smpq_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    smpq_req_if.sink          req,
    smpq_rsp_if.source        rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                                   rsp_valid_reg;
    logic signed [smpq_pkg::VALUE_W-1:0]    rsp_max_reg;
    logic [smpq_pkg::COUNT_W-1:0]           rsp_count_reg;
    logic                                   rsp_empty_reg;
    logic [smpq_pkg::STATUS_W-1:0]          rsp_status_reg;

    logic                                   accept;
    logic                                   full;
    logic                                   is_ins;
    logic                                   is_del;
    logic [smpq_pkg::STATUS_W-1:0]          status;
    smpq_pkg::cell_cmd_t                    cell_cmd;

    logic                                   keep       [DEPTH];
    logic signed [smpq_pkg::VALUE_W-1:0]    entries    [DEPTH];
    logic signed [smpq_pkg::VALUE_W-1:0]    entry_next [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign is_ins    = accept && (req.cmd == smpq_pkg::CMD_INSERT);
    assign is_del    = accept && (req.cmd == smpq_pkg::CMD_DELETE);

    assign cell_cmd.ins   = is_ins && !full;
    assign cell_cmd.del   = is_del && (count_reg != '0);
    assign cell_cmd.value = req.value;

    always_comb
    begin
        status = smpq_pkg::ST_OK;
        if (is_ins && full)
            status = smpq_pkg::ST_FULL;
        else if (is_del && (count_reg == '0))
            status = smpq_pkg::ST_EMPTY;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cell_cmd.ins)
            count_next = count_reg + CNT_W'(1);
        else if (cell_cmd.del)
            count_next = count_reg - CNT_W'(1);
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                                 left_keep;
        logic signed [smpq_pkg::VALUE_W-1:0]  left_entry;
        logic signed [smpq_pkg::VALUE_W-1:0]  right_entry;

        if (i == 0)
        begin : g_head
            assign left_keep  = 1'b1;
            assign left_entry = entries[0];
        end
        else
        begin : g_body
            assign left_keep  = keep[i-1];
            assign left_entry = entries[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = entries[i];
        end
        else
        begin : g_mid
            assign right_entry = entries[i+1];
        end

        smpq_cell u_cell (
            .clk         (clk),
            .cmd         (cell_cmd),
            .occupied    (CNT_W'(i) < count_reg),
            .left_keep   (left_keep),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .keep        (keep[i]),
            .entry       (entries[i]),
            .entry_next  (entry_next[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_max_reg    <= (count_next == '0) ? smpq_pkg::EMPTY_MAX : entry_next[0];
            rsp_count_reg  <= smpq_pkg::COUNT_W'(count_next);
            rsp_empty_reg  <= (count_next == '0);
            rsp_status_reg <= status;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.max_value = rsp_max_reg;
    assign rsp.count     = rsp_count_reg;
    assign rsp.empty_res = rsp_empty_reg;
    assign rsp.status    = rsp_status_reg;

    `SMPQ_ASSERT_ALWAYS(a_count_bound, clk, count_reg <= CNT_W'(DEPTH), "count above depth")
    `SMPQ_ASSERT(a_full_drop, clk, rst_n, is_ins && full |=> (rsp_status_reg == smpq_pkg::ST_FULL) && $stable(count_reg), "full insert not flagged")
    `SMPQ_ASSERT(a_head_order, clk, rst_n, (count_reg >= CNT_W'(2)) |-> (entries[0] >= entries[1]), "head out of order")
    `SMPQ_ASSERT(a_rsp_follows, clk, rst_n, accept |=> rsp_valid_reg, "accepted item gave no response")

endmodule

>>> tb/sorted_max_priority_queue_tb.sv
// Testbench for the sorted max priority queue: directed and random items, predicted results.
`timescale 1ns / 1ps

module sorted_max_priority_queue_tb;

    localparam int                           DEPTH       = smpq_pkg::DEPTH_DEF;
    localparam logic [smpq_pkg::CMD_W-1:0]   CMD_UNUSED  = 2'd3;
    localparam int                           STALL_LIMIT = 2000;
    localparam int                           MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [smpq_pkg::VALUE_W-1:0] max_value;
        logic [smpq_pkg::COUNT_W-1:0]        count;
        logic                                empty_res;
        logic [smpq_pkg::STATUS_W-1:0]       status;
    } queue_result_t;

    logic clk;
    logic rst_n;

    smpq_req_if req_ch ();
    smpq_rsp_if rsp_ch ();

    sorted_max_priority_queue #(.DEPTH(DEPTH)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic signed [smpq_pkg::VALUE_W-1:0] stored_values[$];   // descending, head is the maximum
    queue_result_t                       pending_results[$];
    int                                  mismatch_count = 0;
    int                                  stall_cycles = 0;
    int                                  send_idle_pct;
    int                                  rcv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Applies one item to the queue model and returns what the block should answer.
    function automatic queue_result_t apply_to_model(
        logic [smpq_pkg::CMD_W-1:0] cmd,
        logic signed [smpq_pkg::VALUE_W-1:0] value);
        queue_result_t r;
        int            pos;
        r.status = smpq_pkg::ST_OK;
        if (cmd == smpq_pkg::CMD_INSERT)
        begin
            if (stored_values.size() >= DEPTH)
                r.status = smpq_pkg::ST_FULL;
            else
            begin
                pos = 0;
                // a new value goes after every equal one
                while (pos < stored_values.size() && stored_values[pos] >= value)
                    pos++;
                stored_values.insert(pos, value);
            end
        end
        else if (cmd == smpq_pkg::CMD_DELETE)
        begin
            if (stored_values.size() == 0)
                r.status = smpq_pkg::ST_EMPTY;
            else
                void'(stored_values.pop_front());
        end
        r.empty_res = (stored_values.size() == 0);
        r.max_value = r.empty_res ? smpq_pkg::EMPTY_MAX : stored_values[0];
        r.count     = smpq_pkg::COUNT_W'(stored_values.size());
        return r;
    endfunction

    // Prediction on request accept, then check of the accepted response.
    always @(posedge clk)
    begin : monitor
        queue_result_t want;
        queue_result_t got;
        if (rst_n && req_ch.valid && req_ch.ready)
            pending_results.push_back(apply_to_model(req_ch.cmd, req_ch.value));
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.max_value = rsp_ch.max_value;
            got.count     = rsp_ch.count;
            got.empty_res = rsp_ch.empty_res;
            got.status    = rsp_ch.status;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: max=%0d count=%0d empty=%0d status=%0d",
                             got.max_value, got.count, got.empty_res, got.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.max_value !== want.max_value || got.count !== want.count ||
                    got.empty_res !== want.empty_res || got.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: exp max=%0d cnt=%0d emp=%0d st=%0d | got max=%0d cnt=%0d emp=%0d st=%0d",
                                 want.max_value, want.count, want.empty_res, want.status,
                                 got.max_value, got.count, got.empty_res, got.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Watchdog: cycles with no item moving on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_item(input logic [smpq_pkg::CMD_W-1:0] cmd,
                             input logic signed [smpq_pkg::VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd;
        req_ch.value <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    function automatic logic signed [smpq_pkg::VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return $signed($urandom_range(0, 6)) - 3;   // dense small range: many ties
        else if (sel < 50)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic test_empty_cases();
        send_item(smpq_pkg::CMD_PEEK, 32'sh1234_5678);
        send_item(smpq_pkg::CMD_DELETE, 0);
        send_item(CMD_UNUSED, 7);
        send_item(smpq_pkg::CMD_INSERT, -1);   // stored -1 looks like empty except for the flag
        send_item(smpq_pkg::CMD_PEEK, 0);
        send_item(smpq_pkg::CMD_DELETE, 0);
        send_item(smpq_pkg::CMD_DELETE, 0);
    endtask

    task automatic test_extremes_and_ties();
        send_item(smpq_pkg::CMD_INSERT, 32'sh8000_0000);
        send_item(smpq_pkg::CMD_INSERT, 32'sh7fff_ffff);
        send_item(smpq_pkg::CMD_INSERT, 0);
        send_item(smpq_pkg::CMD_INSERT, 5);
        send_item(smpq_pkg::CMD_INSERT, 5);
        send_item(smpq_pkg::CMD_INSERT, -5);
        send_item(CMD_UNUSED, 32'shffff_ffff);
        send_item(smpq_pkg::CMD_DELETE, 0);
        send_item(smpq_pkg::CMD_DELETE, 0);
        send_item(smpq_pkg::CMD_DELETE, 0);
        send_item(smpq_pkg::CMD_PEEK, 0);
        send_item(smpq_pkg::CMD_DELETE, 0);
        send_item(smpq_pkg::CMD_DELETE, 0);
        send_item(smpq_pkg::CMD_DELETE, 0);
    endtask

    // Fill past capacity, then as many mostly-delete items with some peeks, random values.
    task automatic test_fill_drain(input int rounds);
        for (int r = 0; r < rounds; r++)
        begin
            for (int i = 0; i < DEPTH + 2; i++)
                send_item(smpq_pkg::CMD_INSERT, pick_value());
            for (int i = 0; i < DEPTH + 2; i++)
                send_item(($urandom_range(0, 9) == 0) ? smpq_pkg::CMD_PEEK
                                                       : smpq_pkg::CMD_DELETE,
                          pick_value());
        end
    endtask

    // Segments biased toward filling, draining or balanced traffic.
    task automatic test_random_mix(input int items);
        int                         mode;
        int                         roll;
        logic [smpq_pkg::CMD_W-1:0] cmd;
        mode = 0;
        for (int i = 0; i < items; i++)
        begin
            if (i % 32 == 0)
                mode = $urandom_range(0, 2);
            roll = $urandom_range(0, 99);
            case (mode)
                0:       cmd = (roll < 75) ? smpq_pkg::CMD_INSERT :
                               (roll < 90) ? smpq_pkg::CMD_DELETE : smpq_pkg::CMD_PEEK;
                1:       cmd = (roll < 20) ? smpq_pkg::CMD_INSERT :
                               (roll < 90) ? smpq_pkg::CMD_DELETE : smpq_pkg::CMD_PEEK;
                default: cmd = (roll < 45) ? smpq_pkg::CMD_INSERT :
                               (roll < 90) ? smpq_pkg::CMD_DELETE : smpq_pkg::CMD_PEEK;
            endcase
            if (cmd == smpq_pkg::CMD_PEEK && $urandom_range(0, 1) == 0)
                cmd = CMD_UNUSED;
            send_item(cmd, pick_value());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.cmd     = smpq_pkg::CMD_PEEK;
        req_ch.value   = '0;
        rsp_ch.ready   = 1'b0;
        send_idle_pct  = 12;
        rcv_idle_pct   = 72;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_cases();
        test_extremes_and_ties();
        test_fill_drain(2);
        test_random_mix(400);

        send_idle_pct = 72;
        rcv_idle_pct  = 12;
        test_fill_drain(2);
        test_random_mix(400);

        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        test_fill_drain(2);
        test_random_mix(400);

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/smpq_pkg.sv
rtl/smpq_channels.sv
rtl/smpq_cell.sv
rtl/sorted_max_priority_queue.sv
tb/sorted_max_priority_queue_tb.sv
